### src/tor_pkg.sv
// Package for the timed offset regulator: field widths, register indexes,
// request/result/config structs. No dependencies.
`default_nettype none

package tor_pkg;

   localparam int VALUE_W    = 32;  // Q16.16 values and thresholds
   localparam int TICK_W     = 16;  // countdown lengths
   localparam int OFS_W      = 8;   // signed offset
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // Base-case direction: 0 = default when below threshold, 1 = when above
   localparam bit CHECK_ABOVE = 1'b0;

   localparam logic [CSR_IDX_W-1:0] IDX_BASE_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_HIGH_THRESHOLD = 4'd1;
   localparam logic [CSR_IDX_W-1:0] IDX_LOW_THRESHOLD  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] IDX_DOWN_TICKS     = 4'd3;
   localparam logic [CSR_IDX_W-1:0] IDX_UP_TICKS       = 4'd4;
   localparam logic [CSR_IDX_W-1:0] IDX_LOWEST_OFFSET  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] IDX_HIGHEST_OFFSET = 4'd6;
   localparam logic [CSR_IDX_W-1:0] IDX_HOME_OFFSET    = 4'd7;

   typedef struct packed {
      logic signed [VALUE_W-1:0] base_threshold;
      logic signed [VALUE_W-1:0] high_threshold;
      logic signed [VALUE_W-1:0] low_threshold;
      logic        [TICK_W-1:0]  down_ticks;
      logic        [TICK_W-1:0]  up_ticks;
      logic signed [OFS_W-1:0]   lowest_offset;
      logic signed [OFS_W-1:0]   highest_offset;
      logic signed [OFS_W-1:0]   home_offset;
   } cfg_type;

   // Countdown reload strobes caused by a tick-length write
   typedef struct packed {
      logic              down;
      logic              up;
      logic [TICK_W-1:0] ticks;
   } reload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] base_value;
      logic signed [VALUE_W-1:0] regulation_value;
   } item_type;

   typedef struct packed {
      logic signed [OFS_W-1:0] offset_now;
      logic                    went_default;
      logic [TICK_W-1:0]       down_left;
      logic [TICK_W-1:0]       up_left;
   } result_type;

endpackage

`default_nettype wire

### src/tor_req_if.sv
// Request channel of the timed offset regulator: valid/ready plus input fields.
// Depends on tor_pkg.
`default_nettype none

interface tor_req_if import tor_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] base_value;
   logic signed [VALUE_W-1:0] regulation_value;

   modport source (output valid, output base_value, output regulation_value, input ready);
   modport sink   (input valid, input base_value, input regulation_value, output ready);
endinterface

`default_nettype wire

### src/tor_rsp_if.sv
// Result channel of the timed offset regulator: valid/ready plus result fields.
// Depends on tor_pkg.
`default_nettype none

interface tor_rsp_if import tor_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic signed [OFS_W-1:0] offset_now;
   logic                    went_default;
   logic [TICK_W-1:0]       down_left;
   logic [TICK_W-1:0]       up_left;

   modport source (output valid, output offset_now, output went_default,
                   output down_left, output up_left, input ready);
   modport sink   (input valid, input offset_now, input went_default,
                   input down_left, input up_left, output ready);
endinterface

`default_nettype wire

### src/tor_csr.sv
// Configuration registers of the timed offset regulator, with countdown reload strobes.
// Depends on tor_pkg.
`default_nettype none

module tor_csr import tor_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg,
   output reload_type                 reload
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            IDX_BASE_THRESHOLD: cfg_in.base_threshold = csr_data[VALUE_W-1:0];
            IDX_HIGH_THRESHOLD: cfg_in.high_threshold = csr_data[VALUE_W-1:0];
            IDX_LOW_THRESHOLD:  cfg_in.low_threshold  = csr_data[VALUE_W-1:0];
            IDX_DOWN_TICKS:     cfg_in.down_ticks     = csr_data[TICK_W-1:0];
            IDX_UP_TICKS:       cfg_in.up_ticks       = csr_data[TICK_W-1:0];
            IDX_LOWEST_OFFSET:  cfg_in.lowest_offset  = csr_data[OFS_W-1:0];
            IDX_HIGHEST_OFFSET: cfg_in.highest_offset = csr_data[OFS_W-1:0];
            IDX_HOME_OFFSET:    cfg_in.home_offset    = csr_data[OFS_W-1:0];
            default:            cfg_in = cfg_ff;  // drop writes past the list
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg          = cfg_ff;
   assign reload.down  = csr_write && (csr_index == IDX_DOWN_TICKS);
   assign reload.up    = csr_write && (csr_index == IDX_UP_TICKS);
   assign reload.ticks = csr_data[TICK_W-1:0];

endmodule

`default_nettype wire

### src/tor_core.sv
// Offset and countdown state of the timed offset regulator and its one-step update.
// Depends on tor_pkg.
`default_nettype none

module tor_core import tor_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   advance,
   input  item_type    item,
   input  cfg_type     cfg,
   input  reload_type  reload,
   output result_type  result
);

   logic signed [OFS_W-1:0] offset_ff, offset_in;
   logic [TICK_W-1:0]       down_ff, down_in;
   logic [TICK_W-1:0]       up_ff, up_in;

   logic                    hit;
   logic signed [OFS_W-1:0] ofs_mid;
   logic signed [OFS_W-1:0] ofs_new;
   logic [TICK_W-1:0]       down_new;
   logic [TICK_W-1:0]       up_new;

   always_comb begin
      hit = CHECK_ABOVE ? (item.base_value > cfg.base_threshold)
                        : (item.base_value < cfg.base_threshold);
      ofs_mid  = offset_ff;
      down_new = down_ff;
      up_new   = up_ff;
      if (hit) begin
         ofs_mid  = cfg.home_offset;
         down_new = cfg.down_ticks;
         up_new   = cfg.up_ticks;
      end else if (offset_ff > cfg.lowest_offset) begin
         // decrease timer runs first
         if (item.regulation_value > cfg.high_threshold) begin
            if (down_ff != '0) begin
               down_new = down_ff - 1'b1;
            end else begin
               ofs_mid  = offset_ff - 8'sd1;
               down_new = cfg.down_ticks;
            end
         end else if (down_ff < cfg.down_ticks) begin
            down_new = down_ff + 1'b1;
         end
      end
      ofs_new = ofs_mid;
      // increase timer sees the offset left by the decrease timer
      if (!hit && (ofs_mid < cfg.highest_offset)) begin
         if (item.regulation_value < cfg.low_threshold) begin
            if (up_ff != '0) begin
               up_new = up_ff - 1'b1;
            end else begin
               ofs_new = ofs_mid + 8'sd1;
               up_new  = cfg.up_ticks;
            end
         end else if (up_ff < cfg.up_ticks) begin
            up_new = up_ff + 1'b1;
         end
      end
   end

   always_comb begin
      offset_in = offset_ff;
      down_in   = down_ff;
      up_in     = up_ff;
      if (advance) begin
         offset_in = ofs_new;
         down_in   = down_new;
         up_in     = up_new;
      end
      if (reload.down) begin
         down_in = reload.ticks;
      end
      if (reload.up) begin
         up_in = reload.ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         down_ff   <= '0;
         up_ff     <= '0;
      end else begin
         offset_ff <= offset_in;
         down_ff   <= down_in;
         up_ff     <= up_in;
      end
   end

   assign result.offset_now   = ofs_new;
   assign result.went_default = hit;
   assign result.down_left    = down_new;
   assign result.up_left      = up_new;

   // Outside a return to default the offset moves by at most one step
   a_offset_step: assert property (@(posedge clock) disable iff (reset)
      advance && !hit && !reload.down && !reload.up |=>
         (offset_ff == $past(offset_ff)) ||
         (offset_ff == $past(offset_ff) + 8'sd1) ||
         (offset_ff == $past(offset_ff) - 8'sd1))
      else $error("offset moved by more than one step");

endmodule

`default_nettype wire

### src/timed_offset_regulator.sv
// Top level of the timed offset regulator: request register, result register, handshake.
// Depends on tor_pkg, tor_req_if, tor_rsp_if, tor_csr and tor_core.
`default_nettype none

//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------------
//  req_chan | in        | valid / ready      | base_value, regulation_value
//  rsp_chan | out       | valid / ready      | offset_now, went_default, down_left, up_left
//  csr_*    | in        | csr_write (no wait)| csr_index, csr_data
//
//  A request is captured in the request register, updated combinationally against the
//  offset and countdown state and lands in the result register; one request per
//  cycle sustained while the result channel takes results.
//  Reset (synchronous, active high) clears the configuration, the state and both
//  valid flags. A stalled result holds the result register; the request register
//  keeps accepting while the result register can still drain.

module timed_offset_regulator import tor_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   tor_req_if.sink                    req_chan,
   tor_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type    cfg;
   reload_type reload;
   result_type result;

   logic       req_valid_ff, req_valid_in;
   item_type   req_item_ff, req_item_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_item_ff, rsp_item_in;

   logic       advance;
   logic       req_take;

   // Move the held request into the result stage when that stage is free or draining
   assign advance  = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = !req_valid_ff || advance;
   assign req_chan.ready = req_take;

   always_comb begin
      req_valid_in = req_valid_ff;
      req_item_in  = req_item_ff;
      if (req_take) begin
         req_valid_in = req_chan.valid;
         req_item_in.base_value       = req_chan.base_value;
         req_item_in.regulation_value = req_chan.regulation_value;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = result;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;  // drop the delivered result
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      req_item_ff <= req_item_in;
      rsp_item_ff <= rsp_item_in;
   end

   tor_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .reload    (reload)
   );

   tor_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_item_ff),
      .cfg     (cfg),
      .reload  (reload),
      .result  (result)
   );

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.offset_now   = rsp_item_ff.offset_now;
   assign rsp_chan.went_default = rsp_item_ff.went_default;
   assign rsp_chan.down_left    = rsp_item_ff.down_left;
   assign rsp_chan.up_left      = rsp_item_ff.up_left;

   // A full request register only takes a new request when it moves on
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && req_chan.valid && req_take |-> advance)
      else $error("held request overwritten");

   // A result only leaves the result register when it was taken
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid_ff) |-> $past(rsp_chan.ready))
      else $error("result dropped without handshake");

   // A return to default reports fully reloaded countdowns
   a_default_reload: assert property (@(posedge clock) disable iff (reset)
      advance && result.went_default |=>
         rsp_chan.down_left == cfg.down_ticks && rsp_chan.up_left == cfg.up_ticks)
      else $error("default result without reloaded countdowns");

endmodule

`default_nettype wire
